// ----- hdl/convex_hull_doubled_area_unit_assert.svh -----
// Assertion macros for the convex hull doubled area unit.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef CONVEX_HULL_DOUBLED_AREA_UNIT_ASSERT_SVH
`define CONVEX_HULL_DOUBLED_AREA_UNIT_ASSERT_SVH

// Consequent checked at the clock after the antecedent
`define CHDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked at the same clock as the antecedent
`define CHDA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hdl/chda_pkg.sv -----
// Shared types and constants for the convex hull doubled area unit.
// No dependencies.
`timescale 1ns / 1ps

package chda_pkg;

   localparam int DEFAULT_MAX_POINTS = 256;
   localparam int COORD_W = 16;
   localparam int POINT_W = 2 * COORD_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int SUM_W = 40;
   localparam int AREA_W = 34;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [5:0] {
      OP_IDLE,
      OP_LOAD,
      OP_START,
      OP_PV_RD,
      OP_PV_CMP,
      OP_CP_HEAD,
      OP_CP_RD,
      OP_CP_WR,
      OP_SRT_INIT,
      OP_SRT_KEY_RD,
      OP_SRT_KEY,
      OP_SRT_PREV_RD,
      OP_SRT_PREV,
      OP_DIFF,
      OP_MUL,
      OP_CROSS,
      OP_SQ,
      OP_SRT_SHIFT,
      OP_SRT_PUT,
      OP_HUL_RD0,
      OP_HUL_W0,
      OP_HUL_W1,
      OP_HUL_CUR_RD,
      OP_HUL_CUR,
      OP_HUL_TOP_RD,
      OP_HUL_TOP,
      OP_HUL_POP,
      OP_HUL_PUSH,
      OP_AR_INIT,
      OP_AR_BASE,
      OP_AR_RD_B,
      OP_AR_RD_C,
      OP_AR_C,
      OP_AR_ACC,
      OP_FIN
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_START,
      ST_PV_RD,
      ST_PV_CMP,
      ST_CP_HEAD,
      ST_CP_RD,
      ST_CP_WR,
      ST_SRT_INIT,
      ST_S_LOOP,
      ST_S_KEY_RD,
      ST_S_KEY,
      ST_S_CHK,
      ST_S_PREV_RD,
      ST_S_PREV,
      ST_S_DIFF,
      ST_S_MUL,
      ST_S_CROSS,
      ST_S_SQ,
      ST_S_DEC,
      ST_S_SHIFT,
      ST_S_PUT,
      ST_HUL_RD0,
      ST_HUL_W0,
      ST_HUL_W1,
      ST_H_LOOP,
      ST_H_CUR_RD,
      ST_H_CUR,
      ST_H_CHK,
      ST_H_TOP_RD,
      ST_H_TOP,
      ST_H_DIFF,
      ST_H_MUL,
      ST_H_CROSS,
      ST_H_DEC,
      ST_H_POP,
      ST_H_PUSH,
      ST_A_INIT,
      ST_A_BASE,
      ST_A_CHK,
      ST_A_RD_B,
      ST_A_RD_C,
      ST_A_C,
      ST_A_DIFF,
      ST_A_MUL,
      ST_A_CROSS,
      ST_A_ACC,
      ST_FIN
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic n_lt3;
      logic i_eq_n;
      logic i_last;
      logic j_gt1;
      logic top_gt1;
      logic top_ge3;
      logic area_more;
      logic precedes;
      logic cr_pos;
      logic rsp_free;
   } status_type;

endpackage

// ----- hdl/chda_req_if.sv -----
// Input channel: one point per beat.
// Depends on chda_pkg.
`timescale 1ns / 1ps

interface chda_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [chda_pkg::COORD_W-1:0] point_x;
   logic signed [chda_pkg::COORD_W-1:0] point_y;
   logic                                last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ----- hdl/chda_rsp_if.sv -----
// Result channel: one doubled area per set.
// Depends on chda_pkg.
`timescale 1ns / 1ps

interface chda_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [chda_pkg::AREA_W-1:0]  doubled_area;
   logic                         overflow_flag;

   modport source (output valid, doubled_area, overflow_flag, input ready);
   modport sink (input valid, doubled_area, overflow_flag, output ready);
endinterface

// ----- hdl/chda_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module chda_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/chda_ctrl.sv -----
// Sequencer for the hull unit: pivot search, angle sort, scan, fan sum.
// Depends on chda_pkg.
`timescale 1ns / 1ps

module chda_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  chda_pkg::status_type sts,
   output chda_pkg::cmd_type    cmd
);

   chda_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and command
   always_comb begin
      state_in  = state_ff;
      cmd.op    = chda_pkg::OP_IDLE;
      req_ready = 1'b0;
      case (state_ff)
         chda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = chda_pkg::OP_LOAD;
               if (req_last) begin
                  state_in = chda_pkg::ST_START;
               end
            end
         end
         chda_pkg::ST_START: begin
            cmd.op   = chda_pkg::OP_START;
            state_in = sts.n_lt3 ? chda_pkg::ST_FIN : chda_pkg::ST_PV_RD;
         end
         chda_pkg::ST_PV_RD: begin
            cmd.op   = chda_pkg::OP_PV_RD;
            state_in = chda_pkg::ST_PV_CMP;
         end
         chda_pkg::ST_PV_CMP: begin
            cmd.op   = chda_pkg::OP_PV_CMP;
            state_in = sts.i_last ? chda_pkg::ST_CP_HEAD : chda_pkg::ST_PV_RD;
         end
         chda_pkg::ST_CP_HEAD: begin
            cmd.op   = chda_pkg::OP_CP_HEAD;
            state_in = chda_pkg::ST_CP_RD;
         end
         chda_pkg::ST_CP_RD: begin
            cmd.op   = chda_pkg::OP_CP_RD;
            state_in = chda_pkg::ST_CP_WR;
         end
         chda_pkg::ST_CP_WR: begin
            cmd.op   = chda_pkg::OP_CP_WR;
            state_in = sts.i_last ? chda_pkg::ST_SRT_INIT : chda_pkg::ST_CP_RD;
         end
         chda_pkg::ST_SRT_INIT: begin
            cmd.op   = chda_pkg::OP_SRT_INIT;
            state_in = chda_pkg::ST_S_LOOP;
         end
         chda_pkg::ST_S_LOOP: begin
            state_in = sts.i_eq_n ? chda_pkg::ST_HUL_RD0 : chda_pkg::ST_S_KEY_RD;
         end
         chda_pkg::ST_S_KEY_RD: begin
            cmd.op   = chda_pkg::OP_SRT_KEY_RD;
            state_in = chda_pkg::ST_S_KEY;
         end
         chda_pkg::ST_S_KEY: begin
            cmd.op   = chda_pkg::OP_SRT_KEY;
            state_in = chda_pkg::ST_S_CHK;
         end
         chda_pkg::ST_S_CHK: begin
            state_in = sts.j_gt1 ? chda_pkg::ST_S_PREV_RD : chda_pkg::ST_S_PUT;
         end
         chda_pkg::ST_S_PREV_RD: begin
            cmd.op   = chda_pkg::OP_SRT_PREV_RD;
            state_in = chda_pkg::ST_S_PREV;
         end
         chda_pkg::ST_S_PREV: begin
            cmd.op   = chda_pkg::OP_SRT_PREV;
            state_in = chda_pkg::ST_S_DIFF;
         end
         chda_pkg::ST_S_DIFF: begin
            cmd.op   = chda_pkg::OP_DIFF;
            state_in = chda_pkg::ST_S_MUL;
         end
         chda_pkg::ST_S_MUL: begin
            cmd.op   = chda_pkg::OP_MUL;
            state_in = chda_pkg::ST_S_CROSS;
         end
         chda_pkg::ST_S_CROSS: begin
            cmd.op   = chda_pkg::OP_CROSS;
            state_in = chda_pkg::ST_S_SQ;
         end
         chda_pkg::ST_S_SQ: begin
            cmd.op   = chda_pkg::OP_SQ;
            state_in = chda_pkg::ST_S_DEC;
         end
         chda_pkg::ST_S_DEC: begin
            state_in = sts.precedes ? chda_pkg::ST_S_SHIFT : chda_pkg::ST_S_PUT;
         end
         chda_pkg::ST_S_SHIFT: begin
            cmd.op   = chda_pkg::OP_SRT_SHIFT;
            state_in = chda_pkg::ST_S_CHK;
         end
         chda_pkg::ST_S_PUT: begin
            cmd.op   = chda_pkg::OP_SRT_PUT;
            state_in = chda_pkg::ST_S_LOOP;
         end
         chda_pkg::ST_HUL_RD0: begin
            cmd.op   = chda_pkg::OP_HUL_RD0;
            state_in = chda_pkg::ST_HUL_W0;
         end
         chda_pkg::ST_HUL_W0: begin
            cmd.op   = chda_pkg::OP_HUL_W0;
            state_in = chda_pkg::ST_HUL_W1;
         end
         chda_pkg::ST_HUL_W1: begin
            cmd.op   = chda_pkg::OP_HUL_W1;
            state_in = chda_pkg::ST_H_LOOP;
         end
         chda_pkg::ST_H_LOOP: begin
            if (sts.i_eq_n) begin
               state_in = sts.top_ge3 ? chda_pkg::ST_A_INIT : chda_pkg::ST_FIN;
            end else begin
               state_in = chda_pkg::ST_H_CUR_RD;
            end
         end
         chda_pkg::ST_H_CUR_RD: begin
            cmd.op   = chda_pkg::OP_HUL_CUR_RD;
            state_in = chda_pkg::ST_H_CUR;
         end
         chda_pkg::ST_H_CUR: begin
            cmd.op   = chda_pkg::OP_HUL_CUR;
            state_in = chda_pkg::ST_H_CHK;
         end
         chda_pkg::ST_H_CHK: begin
            state_in = sts.top_gt1 ? chda_pkg::ST_H_TOP_RD : chda_pkg::ST_H_PUSH;
         end
         chda_pkg::ST_H_TOP_RD: begin
            cmd.op   = chda_pkg::OP_HUL_TOP_RD;
            state_in = chda_pkg::ST_H_TOP;
         end
         chda_pkg::ST_H_TOP: begin
            cmd.op   = chda_pkg::OP_HUL_TOP;
            state_in = chda_pkg::ST_H_DIFF;
         end
         chda_pkg::ST_H_DIFF: begin
            cmd.op   = chda_pkg::OP_DIFF;
            state_in = chda_pkg::ST_H_MUL;
         end
         chda_pkg::ST_H_MUL: begin
            cmd.op   = chda_pkg::OP_MUL;
            state_in = chda_pkg::ST_H_CROSS;
         end
         chda_pkg::ST_H_CROSS: begin
            cmd.op   = chda_pkg::OP_CROSS;
            state_in = chda_pkg::ST_H_DEC;
         end
         chda_pkg::ST_H_DEC: begin
            state_in = sts.cr_pos ? chda_pkg::ST_H_PUSH : chda_pkg::ST_H_POP;
         end
         chda_pkg::ST_H_POP: begin
            cmd.op   = chda_pkg::OP_HUL_POP;
            state_in = chda_pkg::ST_H_CHK;
         end
         chda_pkg::ST_H_PUSH: begin
            cmd.op   = chda_pkg::OP_HUL_PUSH;
            state_in = chda_pkg::ST_H_LOOP;
         end
         chda_pkg::ST_A_INIT: begin
            cmd.op   = chda_pkg::OP_AR_INIT;
            state_in = chda_pkg::ST_A_BASE;
         end
         chda_pkg::ST_A_BASE: begin
            cmd.op   = chda_pkg::OP_AR_BASE;
            state_in = chda_pkg::ST_A_CHK;
         end
         chda_pkg::ST_A_CHK: begin
            state_in = sts.area_more ? chda_pkg::ST_A_RD_B : chda_pkg::ST_FIN;
         end
         chda_pkg::ST_A_RD_B: begin
            cmd.op   = chda_pkg::OP_AR_RD_B;
            state_in = chda_pkg::ST_A_RD_C;
         end
         chda_pkg::ST_A_RD_C: begin
            cmd.op   = chda_pkg::OP_AR_RD_C;
            state_in = chda_pkg::ST_A_C;
         end
         chda_pkg::ST_A_C: begin
            cmd.op   = chda_pkg::OP_AR_C;
            state_in = chda_pkg::ST_A_DIFF;
         end
         chda_pkg::ST_A_DIFF: begin
            cmd.op   = chda_pkg::OP_DIFF;
            state_in = chda_pkg::ST_A_MUL;
         end
         chda_pkg::ST_A_MUL: begin
            cmd.op   = chda_pkg::OP_MUL;
            state_in = chda_pkg::ST_A_CROSS;
         end
         chda_pkg::ST_A_CROSS: begin
            cmd.op   = chda_pkg::OP_CROSS;
            state_in = chda_pkg::ST_A_ACC;
         end
         chda_pkg::ST_A_ACC: begin
            cmd.op   = chda_pkg::OP_AR_ACC;
            state_in = chda_pkg::ST_A_CHK;
         end
         chda_pkg::ST_FIN: begin
            // hold until the result register is free
            if (sts.rsp_free) begin
               cmd.op   = chda_pkg::OP_FIN;
               state_in = chda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = chda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/chda_dpath.sv -----
// Datapath for the hull unit: point, order and stack RAMs, counters,
// cross product unit, area accumulator and result register.
// Depends on chda_pkg and chda_ram.
`timescale 1ns / 1ps

module chda_dpath #(
   parameter int MAX_POINTS = chda_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  chda_pkg::cmd_type                   cmd,
   output chda_pkg::status_type                sts,
   input  logic signed [chda_pkg::COORD_W-1:0] req_x,
   input  logic signed [chda_pkg::COORD_W-1:0] req_y,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [chda_pkg::AREA_W-1:0]         rsp_area,
   output logic                                rsp_overflow
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = chda_pkg::POINT_W;

   // counters and control registers
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] top_ff, top_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          drop_ff, drop_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload registers
   chda_pkg::point_type pv_ff, pv_in;
   chda_pkg::point_type key_ff, key_in;
   chda_pkg::point_type pa_ff, pa_in;
   chda_pkg::point_type pb_ff, pb_in;
   chda_pkg::point_type pc_ff, pc_in;
   chda_pkg::point_type s1_ff, s1_in;
   logic signed [chda_pkg::DIFF_W-1:0]  dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic signed [chda_pkg::DIFF_W-1:0]  dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic signed [chda_pkg::PROD_W-1:0]  p1_ff, p1_in, p2_ff, p2_in;
   logic signed [chda_pkg::CROSS_W-1:0] cr_ff, cr_in, da_ff, da_in;
   logic signed [chda_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [chda_pkg::AREA_W-1:0]         area_ff, area_in;
   logic                                ovf_ff, ovf_in;

   // RAM ports
   logic          pts_we, ord_we, stk_we;
   logic [AW-1:0] pts_waddr, ord_waddr, stk_waddr;
   logic [AW-1:0] pts_raddr, ord_raddr, stk_raddr;
   logic [PW-1:0] pts_wdata, ord_wdata, stk_wdata;
   logic [PW-1:0] pts_rdata, ord_rdata, stk_rdata;
   chda_pkg::point_type pts_rd, ord_rd, stk_rd, new_pt;

   logic [CW-1:0]                       i_inc, j_dec, top_dec2;
   logic signed [chda_pkg::CROSS_W-1:0] db;
   logic signed [chda_pkg::SUM_W-1:0]   sum_abs;

   function automatic logic signed [chda_pkg::DIFF_W-1:0] DIFF_X(
      input chda_pkg::point_type u, input chda_pkg::point_type v);
      DIFF_X = chda_pkg::DIFF_W'(u.x) - chda_pkg::DIFF_W'(v.x);
   endfunction

   function automatic logic signed [chda_pkg::DIFF_W-1:0] DIFF_Y(
      input chda_pkg::point_type u, input chda_pkg::point_type v);
      DIFF_Y = chda_pkg::DIFF_W'(u.y) - chda_pkg::DIFF_W'(v.y);
   endfunction

   chda_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
      .clock(clock), .we(pts_we), .waddr(pts_waddr), .wdata(pts_wdata),
      .raddr(pts_raddr), .rdata(pts_rdata)
   );

   chda_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ord (
      .clock(clock), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
      .raddr(ord_raddr), .rdata(ord_rdata)
   );

   chda_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   assign pts_rd = chda_pkg::point_type'(pts_rdata);
   assign ord_rd = chda_pkg::point_type'(ord_rdata);
   assign stk_rd = chda_pkg::point_type'(stk_rdata);
   assign new_pt = '{x: req_x, y: req_y};

   assign i_inc    = i_ff + CW'(1);
   assign j_dec    = j_ff - CW'(1);
   assign top_dec2 = top_ff - CW'(2);
   assign db       = chda_pkg::CROSS_W'(p1_ff) + chda_pkg::CROSS_W'(p2_ff);
   assign sum_abs  = sum_ff[chda_pkg::SUM_W-1] ? -sum_ff : sum_ff;

   // status toward the sequencer
   always_comb begin
      sts.n_lt3     = n_ff < CW'(3);
      sts.i_eq_n    = i_ff == n_ff;
      sts.i_last    = i_inc == n_ff;
      sts.j_gt1     = j_ff > CW'(1);
      sts.top_gt1   = top_ff > CW'(1);
      sts.top_ge3   = top_ff >= CW'(3);
      sts.area_more = i_inc < top_ff;
      sts.precedes  = (cr_ff != '0) ? (cr_ff > 0) : (da_ff < db);
      sts.cr_pos    = cr_ff > 0;
      sts.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // execute the current command
   always_comb begin
      n_in = n_ff; i_in = i_ff; j_in = j_ff; top_in = top_ff;
      pidx_in = pidx_ff; drop_in = drop_ff;
      pv_in = pv_ff; key_in = key_ff; s1_in = s1_ff;
      pa_in = pa_ff; pb_in = pb_ff; pc_in = pc_ff;
      dx1_in = dx1_ff; dy1_in = dy1_ff; dx2_in = dx2_ff; dy2_in = dy2_ff;
      p1_in = p1_ff; p2_in = p2_ff; cr_in = cr_ff; da_in = da_ff;
      sum_in = sum_ff; area_in = area_ff; ovf_in = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pts_we = 1'b0; pts_waddr = n_ff[AW-1:0]; pts_wdata = new_pt;
      ord_we = 1'b0; ord_waddr = j_ff[AW-1:0]; ord_wdata = pc_ff;
      stk_we = 1'b0; stk_waddr = top_ff[AW-1:0]; stk_wdata = pc_ff;
      pts_raddr = i_ff[AW-1:0];
      ord_raddr = i_ff[AW-1:0];
      stk_raddr = i_ff[AW-1:0];
      case (cmd.op)
         chda_pkg::OP_LOAD: begin
            // store the point, or drop it when the store is full
            if (n_ff < CW'(MAX_POINTS)) begin
               pts_we = 1'b1;
               n_in   = n_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
         end
         chda_pkg::OP_START: begin
            i_in   = '0;
            sum_in = '0;
         end
         chda_pkg::OP_PV_CMP: begin
            // keep the lowest point by x, then by y
            if (i_ff == '0 || pts_rd.x < pv_ff.x ||
                (pts_rd.x == pv_ff.x && pts_rd.y < pv_ff.y)) begin
               pv_in   = pts_rd;
               pidx_in = i_ff[AW-1:0];
            end
            i_in = i_inc;
         end
         chda_pkg::OP_CP_HEAD: begin
            ord_we    = 1'b1;
            ord_waddr = '0;
            ord_wdata = pv_ff;
            j_in      = CW'(1);
            i_in      = '0;
         end
         chda_pkg::OP_CP_WR: begin
            // copy every point but the pivot behind it
            if (i_ff[AW-1:0] != pidx_ff) begin
               ord_we    = 1'b1;
               ord_wdata = pts_rd;
               j_in      = j_ff + CW'(1);
            end
            i_in = i_inc;
         end
         chda_pkg::OP_SRT_INIT: begin
            i_in = CW'(2);
         end
         chda_pkg::OP_SRT_KEY: begin
            key_in = ord_rd;
            j_in   = i_ff;
         end
         chda_pkg::OP_SRT_PREV_RD: begin
            ord_raddr = j_dec[AW-1:0];
         end
         chda_pkg::OP_SRT_PREV: begin
            pa_in = pv_ff;
            pb_in = key_ff;
            pc_in = ord_rd;
         end
         chda_pkg::OP_DIFF: begin
            dx1_in = DIFF_X(pb_ff, pa_ff);
            dy1_in = DIFF_Y(pb_ff, pa_ff);
            dx2_in = DIFF_X(pc_ff, pa_ff);
            dy2_in = DIFF_Y(pc_ff, pa_ff);
         end
         chda_pkg::OP_MUL: begin
            p1_in = dx1_ff * dy2_ff;
            p2_in = dx2_ff * dy1_ff;
         end
         chda_pkg::OP_CROSS: begin
            cr_in = chda_pkg::CROSS_W'(p1_ff) - chda_pkg::CROSS_W'(p2_ff);
            p1_in = dx1_ff * dx1_ff;
            p2_in = dy1_ff * dy1_ff;
         end
         chda_pkg::OP_SQ: begin
            da_in = chda_pkg::CROSS_W'(p1_ff) + chda_pkg::CROSS_W'(p2_ff);
            p1_in = dx2_ff * dx2_ff;
            p2_in = dy2_ff * dy2_ff;
         end
         chda_pkg::OP_SRT_SHIFT: begin
            ord_we    = 1'b1;
            ord_wdata = pc_ff;
            j_in      = j_dec;
         end
         chda_pkg::OP_SRT_PUT: begin
            ord_we    = 1'b1;
            ord_wdata = key_ff;
            i_in      = i_inc;
         end
         chda_pkg::OP_HUL_RD0: begin
            ord_raddr = '0;
         end
         chda_pkg::OP_HUL_W0: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = ord_rd;
            ord_raddr = AW'(1);
         end
         chda_pkg::OP_HUL_W1: begin
            stk_we    = 1'b1;
            stk_waddr = AW'(1);
            stk_wdata = ord_rd;
            s1_in     = ord_rd;
            top_in    = CW'(2);
            i_in      = CW'(2);
         end
         chda_pkg::OP_HUL_CUR: begin
            pc_in = ord_rd;
         end
         chda_pkg::OP_HUL_TOP_RD: begin
            stk_raddr = top_dec2[AW-1:0];
         end
         chda_pkg::OP_HUL_TOP: begin
            pa_in = stk_rd;
            pb_in = s1_ff;
         end
         chda_pkg::OP_HUL_POP: begin
            top_in = top_ff - CW'(1);
            s1_in  = pa_ff;
         end
         chda_pkg::OP_HUL_PUSH: begin
            stk_we = 1'b1;
            s1_in  = pc_ff;
            top_in = top_ff + CW'(1);
            i_in   = i_inc;
         end
         chda_pkg::OP_AR_INIT: begin
            stk_raddr = '0;
            i_in      = CW'(1);
         end
         chda_pkg::OP_AR_BASE: begin
            pa_in = stk_rd;
         end
         chda_pkg::OP_AR_RD_C: begin
            pb_in     = stk_rd;
            stk_raddr = i_inc[AW-1:0];
         end
         chda_pkg::OP_AR_C: begin
            pc_in = stk_rd;
         end
         chda_pkg::OP_AR_ACC: begin
            sum_in = sum_ff + chda_pkg::SUM_W'(cr_ff);
            i_in   = i_inc;
         end
         chda_pkg::OP_FIN: begin
            // publish the result and open a new set
            area_in      = sum_abs[chda_pkg::AREA_W-1:0];
            ovf_in       = drop_ff;
            rsp_valid_in = 1'b1;
            n_in         = '0;
            drop_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         pidx_ff      <= '0;
      end else begin
         n_ff         <= n_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         pidx_ff      <= pidx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in;
      pv_ff <= pv_in; key_ff <= key_in; s1_ff <= s1_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in;
      dx1_ff <= dx1_in; dy1_ff <= dy1_in; dx2_ff <= dx2_in; dy2_ff <= dy2_in;
      p1_ff <= p1_in; p2_ff <= p2_in; cr_ff <= cr_in; da_ff <= da_in;
      sum_ff <= sum_in; area_ff <= area_in; ovf_ff <= ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_area     = area_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ----- hdl/convex_hull_doubled_area_unit.sv -----
// Convex hull doubled area unit. Points stream in one per beat and are
// stored at one beat per cycle; the beat marked last_point closes the set.
// After that the unit stops taking beats and runs its sequencer: pivot
// search, copy into sort order, insertion sort by angle (up to n*n/2
// comparisons), Graham scan and fan sum, all bound by the single read
// port of each RAM and the shared cross product unit. The result sits in
// an output register and the next set may load while it waits. Sets of
// fewer than three points give zero; overflow_flag reports points dropped
// on a full store.
// Depends on chda_pkg, the channel interfaces, chda_ctrl and chda_dpath.
`timescale 1ns / 1ps

`include "convex_hull_doubled_area_unit_assert.svh"

module convex_hull_doubled_area_unit #(
   parameter int MAX_POINTS = chda_pkg::DEFAULT_MAX_POINTS
) (
   input logic        clock,
   input logic        reset,
   chda_req_if.sink   req_ch,
   chda_rsp_if.source rsp_ch
);

   chda_pkg::cmd_type    cmd;
   chda_pkg::status_type sts;

   chda_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_last(req_ch.last_point),
      .req_ready(req_ch.ready),
      .sts(sts),
      .cmd(cmd)
   );

   chda_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_x(req_ch.point_x),
      .req_y(req_ch.point_y),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_area(rsp_ch.doubled_area),
      .rsp_overflow(rsp_ch.overflow_flag)
   );

   // a closing beat starts the computation, so the input stalls next cycle
   `CHDA_ASSERT_NEXT(a_busy_after_last, req_ch.valid && req_ch.ready && req_ch.last_point, !req_ch.ready, "input not stalled after closing beat")
   // a new result only comes out of a computation phase
   `CHDA_ASSERT_SAME(a_rsp_after_compute, $rose(rsp_ch.valid), $past(!req_ch.ready), "result without computation")

endmodule
